// ===== design/sgd_pkg.sv =====
// ----------------------------------------------------------------------------
// sgd_pkg
// Shared types, codes and helpers for the sequence gap detector.
// ----------------------------------------------------------------------------
package sgd_pkg;

	localparam int SEQ_W  = 32;
	localparam int CNT_W  = 32;
	localparam int MODE_W = 2;
	localparam int OUT_W  = 328;  // result item packed and padded to whole bytes
	localparam int ADDR_W = 3;

	// verdict codes
	localparam logic [2:0] V_FIRST    = 3'd0;
	localparam logic [2:0] V_IN_ORDER = 3'd1;
	localparam logic [2:0] V_DUP      = 3'd2;
	localparam logic [2:0] V_GAP      = 3'd3;
	localparam logic [2:0] V_REORDER  = 3'd4;

	// width mode codes
	localparam logic [MODE_W-1:0] MODE_8  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_16 = 2'd1;
	localparam logic [MODE_W-1:0] MODE_32 = 2'd2;

	localparam logic [ADDR_W-3:0] REG_WIDTH_MODE = 1'b0;

	// first member lands in the highest bits
	typedef struct packed {
		logic [CNT_W-1:0] wrap_total;
		logic [CNT_W-1:0] worst_run_loss;
		logic [CNT_W-1:0] run_loss;
		logic [CNT_W-1:0] reorder_total;
		logic [CNT_W-1:0] duplicate_total;
		logic [CNT_W-1:0] gap_total;
		logic [CNT_W-1:0] lost_total;
		logic [CNT_W-1:0] received_total;
		logic             wrapped;
		logic [SEQ_W-1:0] lost_in_gap;
		logic [SEQ_W-1:0] expected_before;
		logic [2:0]       verdict;
	} sgd_result_t;

	typedef struct packed {
		logic              clear;
		logic [MODE_W-1:0] mode;
	} sgd_cfg_t;

	function automatic logic [SEQ_W-1:0] seq_mask(input logic [MODE_W-1:0] mode);
		logic [SEQ_W-1:0] m;
		case (mode)
			MODE_8:  m = 32'h0000_00FF;
			MODE_16: m = 32'h0000_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

endpackage

// ===== design/sgd_apb_regs.sv =====
// ----------------------------------------------------------------------------
// sgd_apb_regs
// APB register file: width mode register, clear pulse on write.
// ----------------------------------------------------------------------------
module sgd_apb_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [sgd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output sgd_pkg::sgd_cfg_t         cfg
);
	import sgd_pkg::*;

	logic [MODE_W-1:0] mode_q;
	logic              wr_hit;

	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite &&
		(paddr[ADDR_W-1:2] == REG_WIDTH_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_16;
		end else if (wr_hit) begin
			mode_q <= pwdata[MODE_W-1:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[ADDR_W-1:2] == REG_WIDTH_MODE) begin
			prdata = {{(32-MODE_W){1'b0}}, mode_q};
		end
	end

	// clear pulse is combinational; tracking state drops at the write edge
	assign cfg.clear = wr_hit;
	assign cfg.mode  = mode_q;

endmodule

// ===== design/sgd_track.sv =====
// ----------------------------------------------------------------------------
// sgd_track
// Tracking state, counters and combinational classification of one item.
// ----------------------------------------------------------------------------
module sgd_track (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  sgd_pkg::sgd_cfg_t          cfg,
	input  logic [sgd_pkg::SEQ_W-1:0]  seq_raw,
	output sgd_pkg::sgd_result_t       res
);
	import sgd_pkg::*;

	logic             started_q;
	logic [SEQ_W-1:0] expected_q;
	logic [SEQ_W-1:0] last_q;
	logic [CNT_W-1:0] recv_q, lost_q, gap_q, dup_q, reord_q, run_q, worst_q, wrap_q;

	logic [SEQ_W-1:0] mask, seq, seq_next, diff_fwd, diff_back, lost;
	logic             is_dup, is_in, is_gap, behind;
	logic [CNT_W-1:0] recv_n, lost_n, gap_n, dup_n, reord_n, run_n, worst_n, wrap_n;
	logic [2:0]       verdict;
	logic             upd_last, upd_exp;

	always_comb begin
		mask      = seq_mask(cfg.mode);
		seq       = seq_raw & mask;
		seq_next  = (seq + 32'd1) & mask;
		behind    = seq < expected_q;
		diff_back = expected_q - seq;
		diff_fwd  = (seq - expected_q) & mask;
		is_dup    = started_q && (seq == last_q);
		is_in     = started_q && !is_dup && (seq == expected_q);
		is_gap    = started_q && !is_dup && !is_in &&
			(!behind || (diff_back > (mask >> 1)));
		lost      = is_gap ? diff_fwd : '0;

		recv_n  = sat_add(recv_q, 32'd1);
		lost_n  = lost_q;
		gap_n   = gap_q;
		dup_n   = dup_q;
		reord_n = reord_q;
		run_n   = run_q;
		worst_n = worst_q;
		wrap_n  = wrap_q;
		upd_last = 1'b1;
		upd_exp  = 1'b1;

		if (!started_q) begin
			verdict = V_FIRST;
		end else if (is_dup) begin
			verdict  = V_DUP;
			dup_n    = sat_add(dup_q, 32'd1);
			upd_last = 1'b0;
			upd_exp  = 1'b0;
		end else if (is_in) begin
			verdict = V_IN_ORDER;
			run_n   = '0;
		end else if (is_gap) begin
			verdict = V_GAP;
			if (behind) begin
				wrap_n = sat_add(wrap_q, 32'd1);
			end
			gap_n  = sat_add(gap_q, 32'd1);
			lost_n = sat_add(lost_q, lost);
			run_n  = sat_add(run_q, lost);
			if (run_n > worst_q) begin
				worst_n = run_n;
			end
		end else begin
			verdict = V_REORDER;
			reord_n = sat_add(reord_q, 32'd1);
			upd_exp = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q  <= 1'b0;
			expected_q <= '0;
			last_q     <= '0;
			recv_q     <= '0;
			lost_q     <= '0;
			gap_q      <= '0;
			dup_q      <= '0;
			reord_q    <= '0;
			run_q      <= '0;
			worst_q    <= '0;
			wrap_q     <= '0;
		end else if (cfg.clear) begin
			// counters survive a width change
			started_q  <= 1'b0;
			expected_q <= '0;
			last_q     <= '0;
		end else if (step) begin
			started_q <= 1'b1;
			if (upd_last) begin
				last_q <= seq;
			end
			if (upd_exp) begin
				expected_q <= seq_next;
			end
			recv_q  <= recv_n;
			lost_q  <= lost_n;
			gap_q   <= gap_n;
			dup_q   <= dup_n;
			reord_q <= reord_n;
			run_q   <= run_n;
			worst_q <= worst_n;
			wrap_q  <= wrap_n;
		end
	end

	always_comb begin
		res.verdict         = verdict;
		res.expected_before = expected_q;
		res.lost_in_gap     = lost;
		res.wrapped         = is_gap && behind;
		res.received_total  = recv_n;
		res.lost_total      = lost_n;
		res.gap_total       = gap_n;
		res.duplicate_total = dup_n;
		res.reorder_total   = reord_n;
		res.run_loss        = run_n;
		res.worst_run_loss  = worst_n;
		res.wrap_total      = wrap_n;
	end

	a_worst_covers_run: assert property (@(posedge clk) disable iff (!arst_n)
		worst_q >= run_q)
		else $error("worst run loss below current run loss");

	a_idle_tracking_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!started_q |-> (expected_q == '0) && (last_q == '0))
		else $error("tracking state set before first item");

	a_step_starts: assert property (@(posedge clk) disable iff (!arst_n)
		step && !cfg.clear |=> started_q)
		else $error("tracking not started after an item");

	a_expected_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(expected_q & ~mask) == '0)
		else $error("expected number outside configured width");

endmodule

// ===== design/sequence_gap_detector_top.sv =====
// ----------------------------------------------------------------------------
// sequence_gap_detector_top
// The input reg loads on s_axis accept; the result reg loads when it is free
// or being drained; classification is combinational, counters update on that edge.
// Throughput: one item per cycle unless m_axis_tready stalls the result reg.
// Reset: arst_n async low; clears tracking, counters, valids; width mode = 16 bit.
// A width mode write clears tracking state (first/expected/last) but keeps counters.
// ----------------------------------------------------------------------------
module sequence_gap_detector_top (
	input  logic                        clk,
	input  logic                        arst_n,
	// input stream: tdata[31:0] = seq_number
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [31:0]                 s_axis_tdata,
	// result stream, from bit 0 up: verdict[2:0], expected_before[34:3],
	// lost_in_gap[66:35], wrapped[67], received_total[99:68],
	// lost_total[131:100], gap_total[163:132], duplicate_total[195:164],
	// reorder_total[227:196], run_loss[259:228], worst_run_loss[291:260],
	// wrap_total[323:292], zero pad[327:324]
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [sgd_pkg::OUT_W-1:0]   m_axis_tdata,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sgd_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import sgd_pkg::*;

	sgd_cfg_t         cfg;
	sgd_result_t      res;

	// input stage
	logic             in_valid_s1;
	logic [SEQ_W-1:0] seq_s1;
	// result stage
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic             advance;

	// stage 1 moves into the result register when that register is free or
	// being drained this cycle; the state update rides on the same edge
	assign advance       = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;

	sgd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sgd_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.cfg     (cfg),
		.seq_raw (seq_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			seq_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {{(OUT_W - $bits(sgd_result_t)){1'b0}}, res};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
